[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define CHK_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsb check failed");

// next-cycle implication, quiet while reset is asserted
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsb check failed");

`endif

[src/hsb_pkg.sv]
// shared constants, types and helpers for the hsb to rgb duty converter
package hsb_pkg;

	localparam int unsigned DUTY_BITS = 13;

	localparam int unsigned HUE_W   = 12;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned REM_W   = 10;
	localparam int unsigned LEVEL_W = 16;

	localparam logic [HUE_W-1:0]   HUE_FULL    = 12'd3600;
	localparam logic [HUE_W-1:0]   SECTOR_SPAN = 12'd600;
	localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 16'd60000;

	// level denominator 6000000 = 2^7 * 46875
	localparam int unsigned DEN_SHIFT = 7;
	localparam int unsigned DIV_ODD   = 46875;
	localparam int unsigned RECIP_W   = 17;
	localparam int unsigned RECIP_SH  = 32;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SH) / 64'(DIV_ODD));

	localparam int unsigned NUM_W = PCT_W + LEVEL_W;
	localparam int unsigned Y_W   = NUM_W + DUTY_BITS - DEN_SHIFT;

	localparam int unsigned PIPE_DEPTH = 5;
	localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);

	typedef enum logic [2:0] {
		SEC_R_TO_Y,
		SEC_Y_TO_G,
		SEC_G_TO_C,
		SEC_C_TO_B,
		SEC_B_TO_M,
		SEC_M_TO_R
	} hsb_sector_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} hsb_stage_en_t;

	function automatic logic [HUE_W-1:0] sector_base(input hsb_sector_t sec);
		logic [HUE_W-1:0] base;
		case (sec)
			SEC_R_TO_Y: base = 12'd0;
			SEC_Y_TO_G: base = 12'd600;
			SEC_G_TO_C: base = 12'd1200;
			SEC_C_TO_B: base = 12'd1800;
			SEC_B_TO_M: base = 12'd2400;
			SEC_M_TO_R: base = 12'd3000;
			default:    base = 12'd0;
		endcase
		return base;
	endfunction

endpackage

[src/hsb_req_if.sv]
// color request channel: hue, saturation, brightness and on flag
interface hsb_req_if;
	import hsb_pkg::*;

	logic               valid;
	logic               ready;
	logic [HUE_W-1:0]   hue_tenths;
	logic [PCT_W-1:0]   saturation_pct;
	logic [PCT_W-1:0]   brightness_pct;
	logic               light_on;

	modport source (
		output valid, hue_tenths, saturation_pct, brightness_pct, light_on,
		input  ready
	);

	modport sink (
		input  valid, hue_tenths, saturation_pct, brightness_pct, light_on,
		output ready
	);
endinterface

[src/hsb_duty_if.sv]
// duty result channel: red, green and blue pwm duties
interface hsb_duty_if;
	import hsb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] red_duty;
	logic [DUTY_BITS-1:0] green_duty;
	logic [DUTY_BITS-1:0] blue_duty;

	modport source (
		output valid, red_duty, green_duty, blue_duty,
		input  ready
	);

	modport sink (
		input  valid, red_duty, green_duty, blue_duty,
		output ready
	);
endinterface

[src/hsb_duty_div.sv]
// one channel: level numerator scaled to duty range and divided by the level denominator
module hsb_duty_div (
	input  logic                          clk,
	input  hsb_pkg::hsb_stage_en_t        stage_en,
	input  logic [hsb_pkg::PCT_W-1:0]     bri_s2,
	input  logic [hsb_pkg::LEVEL_W-1:0]   level_s2,
	output logic [hsb_pkg::DUTY_BITS-1:0] duty_s5
);
	import hsb_pkg::*;

	localparam int unsigned PROD_W = NUM_W + DUTY_BITS;
	localparam int unsigned EST_W  = Y_W + RECIP_W;

	logic [NUM_W-1:0]     num;
	logic [PROD_W-1:0]    scaled;
	logic [Y_W-1:0]       y_s3;
	logic [Y_W-1:0]       y_s4;
	logic [EST_W-1:0]     est;
	logic [DUTY_BITS-1:0] qe_s4;
	logic [Y_W-1:0]       back;
	logic [Y_W-1:0]       rem;

	// num * (2^DUTY_BITS - 1) as shift and subtract, then drop the power-of-two part of the divisor
	assign num    = NUM_W'(bri_s2) * NUM_W'(level_s2);
	assign scaled = {num, {DUTY_BITS{1'b0}}} - PROD_W'(num);

	always_ff @(posedge clk) begin
		if (stage_en.s3) begin
			y_s3 <= scaled[PROD_W-1:DEN_SHIFT];
		end
	end

	// reciprocal estimate is exact or one short
	assign est = EST_W'(y_s3) * EST_W'(RECIP);

	always_ff @(posedge clk) begin
		if (stage_en.s4) begin
			y_s4  <= y_s3;
			qe_s4 <= est[RECIP_SH +: DUTY_BITS];
		end
	end

	assign back = Y_W'(qe_s4) * Y_W'(DIV_ODD);
	assign rem  = y_s4 - back;

	always_ff @(posedge clk) begin
		if (stage_en.s5) begin
			duty_s5 <= qe_s4 + DUTY_BITS'(rem >= Y_W'(DIV_ODD));
		end
	end
endmodule

[src/hsb_to_rgb_duty_core.sv]
// HSB to RGB PWM duty converter: takes one color request per clock unless stalled; the red,
// green and blue duties come out of a five-stage pipeline (sector split, p/q/t terms, scale,
// reciprocal estimate, correction); a stalled result holds its stage while earlier stages keep
// filling, so up to five requests are held and sustained throughput is one request per cycle
// whenever the sink is ready.
module hsb_to_rgb_duty_core (
	input logic        clk,
	input logic        arst_n,
	hsb_req_if.sink    req,
	hsb_duty_if.source duty
);
	import hsb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic [HUE_W-1:0]   hue_c;
	hsb_sector_t        sector_c;
	logic [PCT_W-1:0]   sat_c;
	logic [PCT_W-1:0]   bri_c;

	hsb_sector_t        sector_s1;
	logic [REM_W-1:0]   rem_s1;
	logic [PCT_W-1:0]   sat_s1;
	logic [PCT_W-1:0]   bri_s1;
	logic               on_s1;

	logic [LEVEL_W-1:0] lvl_p, lvl_q, lvl_t;
	logic [LEVEL_W-1:0] lvl_r, lvl_g, lvl_b;

	logic [LEVEL_W-1:0] red_s2, green_s2, blue_s2;
	logic [PCT_W-1:0]   bri_s2;
	logic               on_s2, on_s3, on_s4, on_s5;

	logic [DUTY_BITS-1:0] red_s5, green_s5, blue_s5;
	hsb_stage_en_t        stage_en;

	// each stage moves when it is empty or the next one moves
	assign en_s5 = !valid_s5 || duty.ready;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign req.ready = en_s1;

	assign stage_en = '{s3: en_s3, s4: en_s4, s5: en_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= req.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: clamp and sector split
	always_comb begin
		hue_c = (req.hue_tenths >= HUE_FULL) ? '0 : req.hue_tenths;
		sat_c = (req.saturation_pct > PCT_FULL) ? PCT_FULL : req.saturation_pct;
		bri_c = (req.brightness_pct > PCT_FULL) ? PCT_FULL : req.brightness_pct;
		if (hue_c >= 12'd3000) begin
			sector_c = SEC_M_TO_R;
		end else if (hue_c >= 12'd2400) begin
			sector_c = SEC_B_TO_M;
		end else if (hue_c >= 12'd1800) begin
			sector_c = SEC_C_TO_B;
		end else if (hue_c >= 12'd1200) begin
			sector_c = SEC_G_TO_C;
		end else if (hue_c >= SECTOR_SPAN) begin
			sector_c = SEC_Y_TO_G;
		end else begin
			sector_c = SEC_R_TO_Y;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sector_s1 <= sector_c;
			rem_s1    <= REM_W'(hue_c - sector_base(sector_c));
			sat_s1    <= sat_c;
			bri_s1    <= bri_c;
			on_s1     <= req.light_on;
		end
	end

	// stage 2: p, q, t levels over 60000 and channel assignment
	always_comb begin
		lvl_p = LEVEL_W'(PCT_FULL - sat_s1) * LEVEL_W'(SECTOR_SPAN);
		lvl_q = LEVEL_FULL - LEVEL_W'(sat_s1) * LEVEL_W'(rem_s1);
		lvl_t = LEVEL_FULL - LEVEL_W'(sat_s1) * (LEVEL_W'(SECTOR_SPAN) - LEVEL_W'(rem_s1));
		case (sector_s1)
			SEC_R_TO_Y: begin
				lvl_r = LEVEL_FULL; lvl_g = lvl_t;      lvl_b = lvl_p;
			end
			SEC_Y_TO_G: begin
				lvl_r = lvl_q;      lvl_g = LEVEL_FULL; lvl_b = lvl_p;
			end
			SEC_G_TO_C: begin
				lvl_r = lvl_p;      lvl_g = LEVEL_FULL; lvl_b = lvl_t;
			end
			SEC_C_TO_B: begin
				lvl_r = lvl_p;      lvl_g = lvl_q;      lvl_b = LEVEL_FULL;
			end
			SEC_B_TO_M: begin
				lvl_r = lvl_t;      lvl_g = lvl_p;      lvl_b = LEVEL_FULL;
			end
			default: begin
				lvl_r = LEVEL_FULL; lvl_g = lvl_p;      lvl_b = lvl_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			red_s2   <= lvl_r;
			green_s2 <= lvl_g;
			blue_s2  <= lvl_b;
			bri_s2   <= bri_s1;
			on_s2    <= on_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) on_s3 <= on_s2;
		if (en_s4) on_s4 <= on_s3;
		if (en_s5) on_s5 <= on_s4;
	end

	hsb_duty_div u_div_red (
		.clk      (clk),
		.stage_en (stage_en),
		.bri_s2   (bri_s2),
		.level_s2 (red_s2),
		.duty_s5  (red_s5)
	);

	hsb_duty_div u_div_green (
		.clk      (clk),
		.stage_en (stage_en),
		.bri_s2   (bri_s2),
		.level_s2 (green_s2),
		.duty_s5  (green_s5)
	);

	hsb_duty_div u_div_blue (
		.clk      (clk),
		.stage_en (stage_en),
		.bri_s2   (bri_s2),
		.level_s2 (blue_s2),
		.duty_s5  (blue_s5)
	);

	// light off forces black
	assign duty.valid      = valid_s5;
	assign duty.red_duty   = on_s5 ? red_s5 : '0;
	assign duty.green_duty = on_s5 ? green_s5 : '0;
	assign duty.blue_duty  = on_s5 ? blue_s5 : '0;
endmodule

[src/hsb_chk.sv]
// port-level checker for the hsb to rgb duty converter, bound to the top level
`include "assert_macros.svh"

module hsb_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [hsb_pkg::DUTY_BITS-1:0] red_duty,
	input logic [hsb_pkg::DUTY_BITS-1:0] green_duty,
	input logic [hsb_pkg::DUTY_BITS-1:0] blue_duty
);
	import hsb_pkg::*;

	logic [CNT_W-1:0] pending_q;
	logic             req_take;
	logic             rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// requests accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + CNT_W'(req_take) - CNT_W'(rsp_take);
		end
	end

	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`CHK_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(red_duty) && $stable(green_duty) && $stable(blue_duty))
	`CHK_IMPLY(a_no_extra_rsp, clk, arst_n, rsp_valid, pending_q != '0)
	`CHK_IMPLY(a_depth_bound, clk, arst_n, 1'b1, pending_q <= CNT_W'(PIPE_DEPTH))
	`CHK_IMPLY(a_full_stall, clk, arst_n, (pending_q == CNT_W'(PIPE_DEPTH)) && !rsp_ready, !req_ready)
endmodule

bind hsb_to_rgb_duty_core hsb_chk u_hsb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (duty.valid),
	.rsp_ready  (duty.ready),
	.red_duty   (duty.red_duty),
	.green_duty (duty.green_duty),
	.blue_duty  (duty.blue_duty)
);

[sim/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for hsb_to_rgb_duty_core: directed, random, stall, pause-and-resume and full-rate tests
module tb;
	import hsb_pkg::*;

	localparam longint unsigned DUTY_MAX      = (64'd1 << DUTY_BITS) - 1;
	localparam longint unsigned LEVEL_DEN     = 64'd6000000;
	localparam int unsigned     MAX_CYCLES    = 200000;
	localparam int unsigned     SETTLE_CYCLES = 4 * PIPE_DEPTH;
	localparam int unsigned     REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
		logic             light_on;
	} color_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0] red;
		logic [DUTY_BITS-1:0] green;
		logic [DUTY_BITS-1:0] blue;
	} duty_set_t;

	logic        clk = 1'b0;
	logic        arst_n;
	duty_set_t   pending_duties[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          gaps_on = 1'b1;
	int          hold_left = 0;

	hsb_req_if  color_req ();
	hsb_duty_if duty_res ();

	hsb_to_rgb_duty_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (color_req),
		.duty   (duty_res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// exact level numerator over 6000000, scaled to a truncated duty
	function automatic logic [DUTY_BITS-1:0] level_to_duty(input longint unsigned num);
		return DUTY_BITS'((num * DUTY_MAX) / LEVEL_DEN);
	endfunction

	function automatic duty_set_t predict_duties(input color_t c);
		logic [HUE_W-1:0]  h;
		longint unsigned   s, v, rem;
		longint unsigned   n_full, n_p, n_q, n_t, n_r, n_g, n_b;
		hsb_sector_t       sec;
		duty_set_t         d;
		d = '0;
		if (!c.light_on)
			return d;
		h = (c.hue >= HUE_FULL) ? '0 : c.hue;
		s = (c.saturation > PCT_FULL) ? PCT_FULL : c.saturation;
		v = (c.brightness > PCT_FULL) ? PCT_FULL : c.brightness;
		sec = hsb_sector_t'(3'(h / SECTOR_SPAN));
		rem = h % SECTOR_SPAN;
		n_full = v * LEVEL_FULL;
		n_p    = v * (PCT_FULL - s) * SECTOR_SPAN;
		n_q    = v * (LEVEL_FULL - s * rem);
		n_t    = v * (LEVEL_FULL - s * (SECTOR_SPAN - rem));
		case (sec)
			SEC_R_TO_Y: begin n_r = n_full; n_g = n_t;    n_b = n_p;    end
			SEC_Y_TO_G: begin n_r = n_q;    n_g = n_full; n_b = n_p;    end
			SEC_G_TO_C: begin n_r = n_p;    n_g = n_full; n_b = n_t;    end
			SEC_C_TO_B: begin n_r = n_p;    n_g = n_q;    n_b = n_full; end
			SEC_B_TO_M: begin n_r = n_t;    n_g = n_p;    n_b = n_full; end
			default:    begin n_r = n_full; n_g = n_p;    n_b = n_q;    end
		endcase
		d.red   = level_to_duty(n_r);
		d.green = level_to_duty(n_g);
		d.blue  = level_to_duty(n_b);
		return d;
	endfunction

	function automatic logic [PCT_W-1:0] random_pct();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       return '0;
			1:       return PCT_FULL;
			2:       return PCT_W'($urandom_range(101, 127));
			default: return PCT_W'($urandom_range(0, 100));
		endcase
	endfunction

	function automatic color_t random_color();
		color_t      c;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			c.hue = HUE_W'($urandom_range(0, 3599));
		else if (pick < 8)
			// just around a sector boundary, wrap point included
			c.hue = HUE_W'($urandom_range(1, 6) * 600 - 2 + $urandom_range(0, 3));
		else
			c.hue = HUE_W'($urandom_range(3600, 4095));
		c.saturation = random_pct();
		c.brightness = random_pct();
		c.light_on   = ($urandom_range(0, 7) != 0);
		return c;
	endfunction

	function automatic color_t make_color(input int h, input int s, input int b, input bit on);
		color_t c;
		c.hue        = HUE_W'(h);
		c.saturation = PCT_W'(s);
		c.brightness = PCT_W'(b);
		c.light_on   = on;
		return c;
	endfunction

	// four-state compare so unknown outputs are caught
	task automatic check_field(input string name, input logic [DUTY_BITS-1:0] want,
			input logic [DUTY_BITS-1:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		duty_set_t want;
		if (arst_n && duty_res.valid && duty_res.ready) begin
			if (pending_duties.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
						duty_res.red_duty, duty_res.green_duty, duty_res.blue_duty);
			end else begin
				want = pending_duties.pop_front();
				check_field("red_duty", want.red, duty_res.red_duty);
				check_field("green_duty", want.green, duty_res.green_duty);
				check_field("blue_duty", want.blue, duty_res.blue_duty);
			end
		end
	end

	// receiver: hold-off while hold_left is set, otherwise random stall bursts when gaps are on
	initial begin
		int burst_left;
		burst_left = 0;
		duty_res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				duty_res.ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				duty_res.ready <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(0, 11);
				duty_res.ready <= 1'b0;
			end else begin
				duty_res.ready <= 1'b1;
			end
		end
	end

	task automatic send_color(input color_t c);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			color_req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		color_req.valid          <= 1'b1;
		color_req.hue_tenths     <= c.hue;
		color_req.saturation_pct <= c.saturation;
		color_req.brightness_pct <= c.brightness;
		color_req.light_on       <= c.light_on;
		do
			@(posedge clk);
		while (!color_req.ready);
		pending_duties.push_back(predict_duties(c));
	endtask

	task automatic wait_all_results();
		color_req.valid <= 1'b0;
		while (pending_duties.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		color_t list[$];
		list = '{
			make_color(0, 100, 100, 1),    make_color(599, 100, 100, 1),
			make_color(600, 100, 100, 1),  make_color(1199, 73, 88, 1),
			make_color(1200, 100, 100, 1), make_color(1800, 100, 100, 1),
			make_color(2400, 100, 100, 1), make_color(3000, 100, 100, 1),
			make_color(3599, 100, 100, 1), make_color(3600, 100, 100, 1),
			make_color(4095, 50, 60, 1),   make_color(900, 0, 57, 1),
			make_color(2000, 0, 100, 1),   make_color(300, 101, 100, 1),
			make_color(300, 127, 127, 1),  make_color(1500, 100, 101, 1),
			make_color(2700, 60, 0, 1),    make_color(0, 0, 0, 1),
			make_color(4095, 127, 127, 0), make_color(1234, 55, 66, 0),
			make_color(0, 0, 0, 0),        make_color(3333, 1, 1, 1),
			make_color(450, 99, 99, 1)
		};
		gaps_on = 1'b1;
		foreach (list[i])
			send_color(list[i]);
		wait_all_results();
	endtask

	task automatic test_random_colors();
		for (int blk = 0; blk < 13; blk++) begin
			// every third block runs without any idling
			gaps_on = (blk % 3 != 2);
			repeat (40)
				send_color(random_color());
		end
		wait_all_results();
	endtask

	task automatic test_output_stall();
		gaps_on = 1'b0;
		hold_left = 200;
		repeat (40)
			send_color(random_color());
		wait_all_results();
	endtask

	task automatic test_pause_and_resume();
		gaps_on = 1'b1;
		repeat (2) begin
			repeat (20)
				send_color(random_color());
			wait_all_results();
		end
	endtask

	task automatic test_full_rate();
		gaps_on = 1'b0;
		repeat (60)
			send_color(random_color());
		wait_all_results();
	endtask

	initial begin
		arst_n                   = 1'b0;
		color_req.valid          = 1'b0;
		color_req.hue_tenths     = '0;
		color_req.saturation_pct = '0;
		color_req.brightness_pct = '0;
		color_req.light_on       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_colors();
		test_output_stall();
		test_pause_and_resume();
		test_full_rate();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_duties.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
